/* hw/rtl/rmfb_pkg.sv */
// Shared types and constants for the rotated monochrome frame buffer.
// Holds the request and result structs, the command passed from front to back,
// and the function, status and command kind codes. Depends on nothing.
package rmfb_pkg;

  // Default panel geometry.
  localparam int DEF_PANEL_WIDTH  = 400;
  localparam int DEF_PANEL_HEIGHT = 300;

  // Address field of a queued command, wide enough for the largest panel
  // (2048 x 2048 pixels = 524288 bytes). Modules use the low bits they need.
  localparam int CMD_ADDR_W = 19;

  // Entries in the command queue between front and back (a power of two).
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] FILL_ONES  = 8'hFF;
  localparam logic [7:0] FILL_ZEROS = 8'h00;

  // Request function codes.
  localparam logic [1:0] FUNC_DRAW = 2'd0;
  localparam logic [1:0] FUNC_FILL = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_CLIPPED = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  // Command kinds seen by the back end.
  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_FILL  = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  typedef struct packed {
    logic        [1:0]  func;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               color;
    logic        [15:0] byte_index;
  } rmfb_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
  } rmfb_out_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [1:0]            status;
    logic                  color;
    logic [2:0]            bit_sel;
    logic [CMD_ADDR_W-1:0] addr;
  } rmfb_cmd_t;

endpackage

/* hw/rtl/rmfb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package needed.
module rmfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/rmfb_front.sv */
// Front end: accepts requests, clips and rotates draw coordinates, bounds-checks
// reads and pushes one classified command per request into the queue.
// Depends on rmfb_pkg.
module rmfb_front #(
  parameter int PANEL_WIDTH  = rmfb_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = rmfb_pkg::DEF_PANEL_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         rotation,
  input  logic               in_valid,
  output logic               in_stall,
  input  rmfb_pkg::rmfb_in_t in_req,
  input  logic               clearing,
  input  logic               q_full,
  output logic               push,
  output rmfb_pkg::rmfb_cmd_t push_cmd
);

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_DEPTH = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PX_W        = $clog2(PANEL_WIDTH);
  localparam int PY_W        = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
  localparam logic [15:0] W16 = 16'(PANEL_WIDTH);
  localparam logic [15:0] H16 = 16'(PANEL_HEIGHT);

  logic            s1_valid;
  logic [1:0]      s1_kind;
  logic [1:0]      s1_status;
  logic            s1_color;
  logic [PX_W-1:0] s1_px;
  logic [PY_W-1:0] s1_py;
  logic [ADDR_W-1:0] s1_raddr;

  logic [1:0]  kind;
  logic [1:0]  status;
  logic [15:0] lw;
  logic [15:0] lh;
  logic [15:0] xu;
  logic [15:0] yu;
  logic        in_bounds;
  logic [15:0] px_full;
  logic [15:0] py_full;
  logic        read_ok;
  logic [31:0] bidx32;
  logic        accept;
  logic [ADDR_W-1:0] draw_addr;
  logic [ADDR_W-1:0] cmd_addr;

  assign in_stall = clearing || (s1_valid && q_full);
  assign accept   = in_valid && !in_stall;
  assign push     = s1_valid && !q_full;

  // Clip against the rotated size and map to panel coordinates.
  always_comb begin
    xu = in_req.pixel_x;
    yu = in_req.pixel_y;
    lw = rotation[0] ? H16 : W16;
    lh = rotation[0] ? W16 : H16;
    in_bounds = !xu[15] && !yu[15] && (xu < lw) && (yu < lh);
    case (rotation)
      2'd1: begin
        px_full = W16 - 16'd1 - yu;
        py_full = xu;
      end
      2'd2: begin
        px_full = W16 - 16'd1 - xu;
        py_full = H16 - 16'd1 - yu;
      end
      2'd3: begin
        px_full = yu;
        py_full = H16 - 16'd1 - xu;
      end
      default: begin
        px_full = xu;
        py_full = yu;
      end
    endcase
    bidx32  = {16'd0, in_req.byte_index};
    read_ok = bidx32 < 32'(STORE_DEPTH);
    kind    = rmfb_pkg::KIND_REPLY;
    status  = rmfb_pkg::STATUS_DONE;
    case (in_req.func)
      rmfb_pkg::FUNC_DRAW: begin
        if (in_bounds) begin
          kind = rmfb_pkg::KIND_DRAW;
        end else begin
          status = rmfb_pkg::STATUS_CLIPPED;
        end
      end
      rmfb_pkg::FUNC_FILL: begin
        kind = rmfb_pkg::KIND_FILL;
      end
      rmfb_pkg::FUNC_READ: begin
        if (read_ok) begin
          kind = rmfb_pkg::KIND_READ;
        end else begin
          status = rmfb_pkg::STATUS_RANGE;
        end
      end
      default: begin
        kind = rmfb_pkg::KIND_REPLY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind   <= kind;
      s1_status <= status;
      s1_color  <= in_req.color;
      s1_px     <= px_full[PX_W-1:0];
      s1_py     <= py_full[PY_W-1:0];
      s1_raddr  <= bidx32[ADDR_W-1:0];
    end
  end

  // Row start times row length plus byte column.
  assign draw_addr = ADDR_W'(32'(s1_py) * 32'(ROW_BYTES)) + ADDR_W'(s1_px >> 3);
  assign cmd_addr  = (s1_kind == rmfb_pkg::KIND_READ) ? s1_raddr : draw_addr;

  always_comb begin
    push_cmd.kind    = s1_kind;
    push_cmd.status  = s1_status;
    push_cmd.color   = s1_color;
    push_cmd.bit_sel = s1_px[2:0];
    push_cmd.addr    = rmfb_pkg::CMD_ADDR_W'(cmd_addr);
  end

endmodule

/* hw/rtl/rmfb_queue.sv */
// Short command queue that decouples the front end from the back end.
// Depends on rmfb_pkg for the command type and depth.
module rmfb_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rmfb_pkg::rmfb_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output rmfb_pkg::rmfb_cmd_t head,
  output logic                empty
);

  localparam int PTR_W = (rmfb_pkg::QUEUE_DEPTH > 1) ? $clog2(rmfb_pkg::QUEUE_DEPTH) : 1;

  rmfb_pkg::rmfb_cmd_t entries [rmfb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = count == (PTR_W + 1)'(rmfb_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/rmfb_back.sv */
// Back end: carries out queued commands on the frame store (read-modify-write
// draws, reads, fill sweeps), clears the store after reset and holds the
// result register. Depends on rmfb_pkg and rmfb_ram.
module rmfb_back #(
  parameter int PANEL_WIDTH  = rmfb_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = rmfb_pkg::DEF_PANEL_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  rmfb_pkg::rmfb_cmd_t q_head,
  output logic                pop,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_stall,
  output rmfb_pkg::rmfb_out_t out_res
);

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_DEPTH = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DRAW  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] cnt_next;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] cur_addr_next;
  logic [2:0]        cur_bit;
  logic [2:0]        cur_bit_next;
  logic              cur_color;
  logic              cur_color_next;
  logic [7:0]        fill_byte;
  logic [7:0]        fill_byte_next;
  logic              out_valid_next;
  rmfb_pkg::rmfb_out_t out_res_next;

  logic              out_free;
  logic [7:0]        mask;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  assign clearing = state == ST_CLEAR;
  assign out_free = !out_valid || !out_stall;
  assign mask     = 8'h80 >> cur_bit;
  assign raddr    = q_head.addr[ADDR_W-1:0];

  rmfb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cur_addr_next  = cur_addr;
    cur_bit_next   = cur_bit;
    cur_color_next = cur_color;
    fill_byte_next = fill_byte;
    out_valid_next = out_valid && out_stall;
    out_res_next   = out_res;
    pop            = 1'b0;
    we             = 1'b0;
    waddr          = cnt;
    wdata          = fill_byte;
    case (state)
      ST_CLEAR: begin
        we       = 1'b1;
        wdata    = rmfb_pkg::FILL_ZEROS;
        cnt_next = cnt + ADDR_W'(1);
        if (cnt == LAST_ADDR) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          pop = 1'b1;
          case (q_head.kind)
            rmfb_pkg::KIND_DRAW: begin
              cur_addr_next  = q_head.addr[ADDR_W-1:0];
              cur_bit_next   = q_head.bit_sel;
              cur_color_next = q_head.color;
              state_next     = ST_DRAW;
            end
            rmfb_pkg::KIND_READ: begin
              state_next = ST_READ;
            end
            rmfb_pkg::KIND_FILL: begin
              cnt_next       = '0;
              fill_byte_next = q_head.color ? rmfb_pkg::FILL_ONES : rmfb_pkg::FILL_ZEROS;
              state_next     = ST_FILL;
            end
            default: begin
              out_valid_next         = 1'b1;
              out_res_next.read_data = 8'h00;
              out_res_next.status    = q_head.status;
            end
          endcase
        end
      end
      ST_DRAW: begin
        we    = 1'b1;
        waddr = cur_addr;
        wdata = cur_color ? (rdata | mask) : (rdata & ~mask);
        out_valid_next         = 1'b1;
        out_res_next.read_data = 8'h00;
        out_res_next.status    = rmfb_pkg::STATUS_DONE;
        state_next             = ST_IDLE;
      end
      ST_READ: begin
        out_valid_next         = 1'b1;
        out_res_next.read_data = rdata;
        out_res_next.status    = rmfb_pkg::STATUS_DONE;
        state_next             = ST_IDLE;
      end
      ST_FILL: begin
        we       = 1'b1;
        cnt_next = cnt + ADDR_W'(1);
        if (cnt == LAST_ADDR) begin
          cnt_next               = '0;
          out_valid_next         = 1'b1;
          out_res_next.read_data = 8'h00;
          out_res_next.status    = rmfb_pkg::STATUS_DONE;
          state_next             = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_addr  <= cur_addr_next;
    cur_bit   <= cur_bit_next;
    cur_color <= cur_color_next;
    fill_byte <= fill_byte_next;
    out_res   <= out_res_next;
  end

endmodule

/* hw/rtl/rotated_mono_framebuffer_unit.sv */
// Top level of the rotated one-bit-per-pixel frame buffer.
// Depends on rmfb_pkg, rmfb_front, rmfb_queue, rmfb_back and rmfb_ram.
//
// Usage:
// Requests enter on in_valid / in_stall / in_req and each one produces exactly
// one result on out_valid / out_stall / out_res, in request order. A request is
// taken at a rising edge with in_valid high and in_stall low; a result is taken
// at an edge with out_valid high and out_stall low. The rotation register is
// written over cfg_valid / cfg_ready / cfg_data; the user must write it only
// while the block is idle; the block itself does not enforce it. The back end
// answers a clipped pixel, an unused function or an out-of-range read from
// the queue head alone, a draw or an in-range read after its store access and
// a fill after its sweep of the whole store. It runs a draw as a read then a
// write of one store byte and pops no new command until a draw or read is
// done; a fill sweeps one byte a cycle over the whole store.
// After reset the back end clears the store one byte a cycle, over all
// ROW_BYTES * PANEL_HEIGHT bytes (15000 at the default size); in_stall stays
// high until it ends. When the receiver holds out_stall, the result waits in
// the output register, the back end stops popping and the queue and front
// stage fill before in_stall rises.
module rotated_mono_framebuffer_unit #(
  parameter int PANEL_WIDTH  = rmfb_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = rmfb_pkg::DEF_PANEL_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rmfb_pkg::rmfb_in_t  in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output rmfb_pkg::rmfb_out_t out_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data
);

  logic [1:0]          rotation;
  logic                clearing;
  logic                q_full;
  logic                q_empty;
  logic                push;
  logic                pop;
  rmfb_pkg::rmfb_cmd_t push_cmd;
  rmfb_pkg::rmfb_cmd_t q_head;

  // The rotation register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      rotation <= cfg_data;
    end
  end

  // Front stage: clipping, rotation and address generation.
  rmfb_front #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .rotation(rotation),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req  (in_req),
    .clearing(clearing),
    .q_full  (q_full),
    .push    (push),
    .push_cmd(push_cmd)
  );

  // Commands wait here while the back end is busy or the output is stalled.
  rmfb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  // Back end: frame store access and the result register.
  rmfb_back #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .pop      (pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

endmodule
